@@ src/qlfk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlfk_pkg
// Shared types, constants and helpers of the leg forward kinematics unit.
// ----------------------------------------------------------------------------
package qlfk_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int SC_LAT       = CORDIC_STEPS + 2;
  localparam int TRIG_W       = 18;
  localparam int CFG_IDX_W    = 3;

  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sh026DD3B6A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIP_SIDE  = 3'd0,
    REG_UPPER_LEN = 3'd1,
    REG_LOWER_LEN = 3'd2,
    REG_HALF_LEN  = 3'd3,
    REG_HALF_WID  = 3'd4
  } cfg_reg_e;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] r;
    case (i)
      0:  r = 30'h3243F6A8;
      1:  r = 30'h1DAC6705;
      2:  r = 30'h0FADBAFC;
      3:  r = 30'h07F56EA6;
      4:  r = 30'h03FEAB76;
      5:  r = 30'h01FFD55B;
      6:  r = 30'h00FFFAAA;
      7:  r = 30'h007FFF55;
      8:  r = 30'h003FFFEA;
      9:  r = 30'h001FFFFD;
      10: r = 30'h000FFFFF;
      11: r = 30'h0007FFFF;
      12: r = 30'h0003FFFF;
      13: r = 30'h0001FFFF;
      14: r = 30'h0000FFFF;
      15: r = 30'h00007FFF;
      16: r = 30'h00003FFF;
      17: r = 30'h00001FFF;
      18: r = 30'h00000FFF;
      19: r = 30'h000007FF;
      20: r = 30'h000003FF;
      21: r = 30'h000001FF;
      22: r = 30'h000000FF;
      23: r = 30'h0000007F;
      24: r = 30'h0000003F;
      25: r = 30'h0000001F;
      26: r = 30'h0000000F;
      27: r = 30'h00000008;
      28: r = 30'h00000004;
      29: r = 30'h00000002;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp to [-1.0, 1.0] in Q16.
  function automatic logic signed [TRIG_W-1:0] clamp_q16(input logic signed [39:0] v);
    logic signed [TRIG_W-1:0] r;
    if (v > 40'sd65536) begin
      r = 18'sd65536;
    end else if (v < -40'sd65536) begin
      r = -18'sd65536;
    end else begin
      r = v[TRIG_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/qlfk_sincos.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlfk_sincos
// Pipelined rotation CORDIC: one angle in per cycle while en_i is high, Q16 sine and cosine out.
// ----------------------------------------------------------------------------
module qlfk_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [ANGLE_BITS-1:0]          ang_i,
  output logic signed [qlfk_pkg::TRIG_W-1:0]    sin_o,
  output logic signed [qlfk_pkg::TRIG_W-1:0]    cos_o
);
  import qlfk_pkg::*;

  logic signed [34:0] z_in, z_wrap1, z_wrap2;
  logic signed [33:0] z_fold_d;
  logic               neg_d;

  logic signed [32:0] x_q   [0:CORDIC_STEPS];
  logic signed [32:0] y_q   [0:CORDIC_STEPS];
  logic signed [33:0] z_q   [0:CORDIC_STEPS];
  logic               neg_q [0:CORDIC_STEPS];

  logic signed [TRIG_W-1:0] sin_q, cos_q;
  logic signed [39:0]       x_rnd, y_rnd;
  logic signed [TRIG_W-1:0] x_cl, y_cl;

  // Scale to Q30, wrap into [-pi, pi], fold into [-pi/2, pi/2].
  always_comb begin
    z_in    = 35'(ang_i) <<< (33 - ANGLE_BITS);
    z_wrap1 = (z_in > PI_Q30) ? z_in - (PI_Q30 <<< 1) : z_in;
    z_wrap2 = (z_wrap1 < -PI_Q30) ? z_wrap1 + (PI_Q30 <<< 1) : z_wrap1;
    neg_d   = 1'b0;
    z_fold_d = z_wrap2[33:0];
    if (z_wrap2 > HALF_PI_Q30) begin
      z_fold_d = 34'(z_wrap2 - PI_Q30);
      neg_d    = 1'b1;
    end else if (z_wrap2 < -HALF_PI_Q30) begin
      z_fold_d = 34'(z_wrap2 + PI_Q30);
      neg_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= CORDIC_GAIN;
      y_q[0]   <= '0;
      z_q[0]   <= z_fold_d;
      neg_q[0] <= neg_d;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [33:0] At = 34'(atan_q30(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - At;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + At;
        end
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  // Round Q30 to Q16, clamp, apply the half-turn sign.
  always_comb begin
    x_rnd = (40'(x_q[CORDIC_STEPS]) + 40'sd8192) >>> 14;
    y_rnd = (40'(y_q[CORDIC_STEPS]) + 40'sd8192) >>> 14;
    x_cl  = clamp_q16(x_rnd);
    y_cl  = clamp_q16(y_rnd);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= neg_q[CORDIC_STEPS] ? -x_cl : x_cl;
      sin_q <= neg_q[CORDIC_STEPS] ? -y_cl : y_cl;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

@@ src/quadruped_leg_forward_kinematics_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadruped_leg_forward_kinematics_unit
// Foot position of a three-joint leg from its joint angles, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per sample: a
//   leg select and hip, thigh and knee angles in signed Q3.(ANGLE_BITS-3)
//   radians. Output channel (out_valid_o / out_ready_i) carries one beat
//   per input beat, in order: foot x, y, z in body-frame length units.
//   The five geometry registers are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i; write them only while no beat is in flight.
// Throughput: one beat per cycle while the skid register is empty. Three
//   CORDIC pipelines (one step per stage) feed seven multiply/add stages;
//   nothing is shared. Pipeline: 32 CORDIC stages (angle prep, 30 steps,
//   rounding), 7 arithmetic stages, output register.
// Reset: clears all valid bits (pipeline, output and skid) and the geometry
//   registers (all lengths zero); data registers are left as they are.
// Stall: a held output parks the next result in a skid register; the whole
//   pipeline then freezes and in_ready_o drops until the skid drains. No
//   beat is lost or repeated.
// ----------------------------------------------------------------------------
module quadruped_leg_forward_kinematics_unit #(
  parameter int ANGLE_BITS  = 16,
  parameter int LENGTH_BITS = 15
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [qlfk_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [LENGTH_BITS-1:0]                cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            leg_select_i,
  input  logic signed [ANGLE_BITS-1:0]          hip_angle_i,
  input  logic signed [ANGLE_BITS-1:0]          thigh_angle_i,
  input  logic signed [ANGLE_BITS-1:0]          knee_angle_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [LENGTH_BITS+2:0]         foot_x_o,
  output logic signed [LENGTH_BITS+2:0]         foot_y_o,
  output logic signed [LENGTH_BITS+2:0]         foot_z_o
);
  import qlfk_pkg::*;

  localparam int LW  = LENGTH_BITS;
  localparam int OW  = LW + 3;
  localparam int MW  = LW + 19;   // length times Q16 trig
  localparam int AW  = LW + 20;   // a and b
  localparam int HW  = AW - 17;   // upper part of a
  localparam int XW  = LW + 38;   // Q32 position sums
  localparam int NST = SC_LAT + 7;
  localparam logic signed [XW-1:0] Lim = XW'((64'sd1 <<< (LW + 2)) - 64'sd4);

  // Geometry registers.
  logic [LW-1:0] l1_q, l2_q, l3_q, ox_q, oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= '0;
      l2_q <= '0;
      l3_q <= '0;
      ox_q <= '0;
      oy_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HIP_SIDE:  l1_q <= cfg_data_i;
        REG_UPPER_LEN: l2_q <= cfg_data_i;
        REG_LOWER_LEN: l3_q <= cfg_data_i;
        REG_HALF_LEN:  ox_q <= cfg_data_i;
        REG_HALF_WID:  oy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline enable: advance everything unless the skid register is full.
  logic en;
  logic skid_v_q, out_v_q;
  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // Valid bits and leg select travel alongside the data.
  logic       v_q   [0:NST-1];
  logic [1:0] leg_q [0:NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      leg_q[0] <= leg_select_i;
      for (int k = 1; k < NST; k++) leg_q[k] <= leg_q[k-1];
    end
  end

  // Sine and cosine of the three joints.
  logic signed [TRIG_W-1:0] s1, c1, s2, c2, s3, c3;

  qlfk_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_hip (
    .clk_i(clk_i), .en_i(en), .ang_i(hip_angle_i), .sin_o(s1), .cos_o(c1)
  );
  qlfk_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_thigh (
    .clk_i(clk_i), .en_i(en), .ang_i(thigh_angle_i), .sin_o(s2), .cos_o(c2)
  );
  qlfk_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_knee (
    .clk_i(clk_i), .en_i(en), .ang_i(knee_angle_i), .sin_o(s3), .cos_o(c3)
  );

  // Stage A: angle-sum products.
  logic signed [35:0] p_sc_q, p_cs_q, p_cc_q, p_ss_q;
  logic signed [TRIG_W-1:0] s1_a_q, c1_a_q, s2_a_q, c2_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_sc_q <= s2 * c3;
      p_cs_q <= c2 * s3;
      p_cc_q <= c2 * c3;
      p_ss_q <= s2 * s3;
      s1_a_q <= s1;
      c1_a_q <= c1;
      s2_a_q <= s2;
      c2_a_q <= c2;
    end
  end

  // Stage B: sin(q2+q3), cos(q2+q3) rounded and clamped in Q16.
  logic signed [39:0] sum_s, sum_c;
  logic signed [TRIG_W-1:0] s23_q, c23_q, s1_b_q, c1_b_q, s2_b_q, c2_b_q;

  always_comb begin
    sum_s = (40'(p_sc_q) + 40'(p_cs_q) + 40'sd32768) >>> 16;
    sum_c = (40'(p_cc_q) - 40'(p_ss_q) + 40'sd32768) >>> 16;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s23_q  <= clamp_q16(sum_s);
      c23_q  <= clamp_q16(sum_c);
      s1_b_q <= s1_a_q;
      c1_b_q <= c1_a_q;
      s2_b_q <= s2_a_q;
      c2_b_q <= c2_a_q;
    end
  end

  // Stage C: link length products.
  logic signed [MW-1:0] m_l3s_q, m_l2s_q, m_l3c_q, m_l2c_q;
  logic signed [TRIG_W-1:0] s1_c_q, c1_c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_l3s_q <= $signed({1'b0, l3_q}) * s23_q;
      m_l2s_q <= $signed({1'b0, l2_q}) * s2_b_q;
      m_l3c_q <= $signed({1'b0, l3_q}) * c23_q;
      m_l2c_q <= $signed({1'b0, l2_q}) * c2_b_q;
      s1_c_q  <= s1_b_q;
      c1_c_q  <= c1_b_q;
    end
  end

  // Stage D: planar reach a and height b (Q16).
  logic signed [AW-1:0] a_q, b_d_q;
  logic signed [TRIG_W-1:0] s1_d_q, c1_d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q    <= -AW'(m_l3s_q) - AW'(m_l2s_q);
      b_d_q  <= AW'(m_l3c_q) + AW'(m_l2c_q);
      s1_d_q <= s1_c_q;
      c1_d_q <= c1_c_q;
    end
  end

  // Stage E: hip rotation products; a is split to keep each multiplier narrow.
  logic signed [HW-1:0]      a_hi;
  logic signed [17:0]        a_lo;
  logic signed [LW:0]        h;
  logic signed [HW+17:0]     cah_q, sah_q;
  logic signed [35:0]        cal_q, sal_q;
  logic signed [LW+18:0]     sh_q, ch_q;
  logic signed [AW-1:0]      b_e_q;

  always_comb begin
    a_hi = a_q[AW-1:17];
    a_lo = $signed({1'b0, a_q[16:0]});
    h    = leg_q[SC_LAT+3][1] ? -$signed({1'b0, l1_q}) : $signed({1'b0, l1_q});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cah_q <= c1_d_q * a_hi;
      sah_q <= s1_d_q * a_hi;
      cal_q <= c1_d_q * a_lo;
      sal_q <= s1_d_q * a_lo;
      sh_q  <= s1_d_q * h;
      ch_q  <= c1_d_q * h;
      b_e_q <= b_d_q;
    end
  end

  // Stage F: recombine into Q32 x and y.
  logic signed [XW-1:0] px_q, py_q;
  logic signed [AW-1:0] b_f_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q  <= (XW'(cah_q) <<< 17) + XW'(cal_q) - (XW'(sh_q) <<< 16);
      py_q  <= (XW'(sah_q) <<< 17) + XW'(sal_q) + (XW'(ch_q) <<< 16);
      b_f_q <= b_e_q;
    end
  end

  // Stage G: round, add body offsets, saturate.
  logic signed [XW-1:0] rx, ry, rz, off_x, off_y;
  logic signed [OW-1:0] fx_d, fy_d, fz_d;
  logic signed [OW-1:0] fx_q, fy_q, fz_q;
  logic [1:0]           leg_g;

  always_comb begin
    leg_g = leg_q[SC_LAT+5];
    off_x = leg_g[0] ? -XW'($signed({1'b0, ox_q})) : XW'($signed({1'b0, ox_q}));
    off_y = leg_g[1] ? -XW'($signed({1'b0, oy_q})) : XW'($signed({1'b0, oy_q}));
    rx = ((px_q + (XW'(1) <<< 31)) >>> 32) + off_x;
    ry = ((py_q + (XW'(1) <<< 31)) >>> 32) + off_y;
    rz = (-XW'(b_f_q) + (XW'(1) <<< 15)) >>> 16;
    fx_d = (rx > Lim) ? OW'(Lim) : ((rx < -Lim) ? OW'(-Lim) : rx[OW-1:0]);
    fy_d = (ry > Lim) ? OW'(Lim) : ((ry < -Lim) ? OW'(-Lim) : ry[OW-1:0]);
    fz_d = (rz > Lim) ? OW'(Lim) : ((rz < -Lim) ? OW'(-Lim) : rz[OW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q <= fx_d;
      fy_q <= fy_d;
      fz_q <= fz_d;
    end
  end

  // Output register and skid register.
  logic                 tail_v, out_free;
  logic signed [OW-1:0] ox_out_q, oy_out_q, oz_out_q;
  logic signed [OW-1:0] skx_q, sky_q, skz_q;

  assign tail_v   = v_q[NST-1];
  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      // Pipeline moves: the tail goes to the output, or parks in the skid.
      if (out_free) begin
        out_v_q <= tail_v;
      end else if (tail_v) begin
        skid_v_q <= 1'b1;
      end
    end else if (out_free) begin
      // Drain the skid.
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (out_free) begin
        ox_out_q <= fx_q;
        oy_out_q <= fy_q;
        oz_out_q <= fz_q;
      end else begin
        skx_q <= fx_q;
        sky_q <= fy_q;
        skz_q <= fz_q;
      end
    end else if (out_free) begin
      ox_out_q <= skx_q;
      oy_out_q <= sky_q;
      oz_out_q <= skz_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign foot_x_o    = ox_out_q;
  assign foot_y_o    = oy_out_q;
  assign foot_z_o    = oz_out_q;

  // A parked result always sits behind a held output beat.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a beat while output is empty");

  // A finished result meeting a held output must land in the skid.
  a_tail_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && tail_v && out_v_q && !out_ready_i) |=> skid_v_q)
    else $error("result dropped at stalled output");

  // A held output beat is never withdrawn.
  a_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> out_v_q)
    else $error("output beat lost while stalled");

  // The skid empties as soon as the output is taken.
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && out_ready_i) |=> !skid_v_q)
    else $error("skid failed to drain");

endmodule
